### sv/wasm_i32_stack_executor_unit_defines.svh
// Assertion helpers shared by the executor RTL.
`ifndef WASM_I32_STACK_EXECUTOR_UNIT_DEFINES_SVH
`define WASM_I32_STACK_EXECUTOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define WSX_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define WSX_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/wsx_pkg.sv
package wsx_pkg;

    localparam int STACK_DEPTH_DEF      = 1024;
    localparam int MAX_FRAMES_DEF       = 32;
    localparam int LOCALS_PER_FRAME_DEF = 64;
    localparam int MEM_BYTES_DEF        = 65536;

    localparam logic [4:0] ACT_UNREACHABLE = 5'd0;
    localparam logic [4:0] ACT_END         = 5'd1;
    localparam logic [4:0] ACT_DROP        = 5'd2;
    localparam logic [4:0] ACT_CALL        = 5'd3;
    localparam logic [4:0] ACT_LGET        = 5'd4;
    localparam logic [4:0] ACT_LSET        = 5'd5;
    localparam logic [4:0] ACT_CONST       = 5'd6;
    localparam logic [4:0] ACT_LD32        = 5'd7;
    localparam logic [4:0] ACT_LD8         = 5'd8;
    localparam logic [4:0] ACT_ST32        = 5'd9;
    localparam logic [4:0] ACT_ST8         = 5'd10;
    localparam logic [4:0] ACT_EQZ         = 5'd11;
    localparam logic [4:0] ACT_NE          = 5'd12;
    localparam logic [4:0] ACT_LTS         = 5'd13;
    localparam logic [4:0] ACT_GTS         = 5'd14;
    localparam logic [4:0] ACT_EQ          = 5'd15;
    localparam logic [4:0] ACT_ADD         = 5'd16;
    localparam logic [4:0] ACT_SUB         = 5'd17;
    localparam logic [4:0] ACT_MUL         = 5'd18;
    localparam logic [4:0] ACT_IF          = 5'd19;
    localparam logic [4:0] ACT_BR          = 5'd20;
    localparam logic [4:0] ACT_BR_IF       = 5'd21;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_FINISHED    = 3'd1;
    localparam logic [2:0] ST_UNREACHABLE = 3'd2;
    localparam logic [2:0] ST_MEMFAULT    = 3'd3;
    localparam logic [2:0] ST_TOODEEP     = 3'd4;
    localparam logic [2:0] ST_UNDERFLOW   = 3'd5;
    localparam logic [2:0] ST_OVERFLOW    = 3'd6;
    localparam logic [2:0] ST_HALTED      = 3'd7;

    typedef enum logic [2:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_EQ,
        ALU_NE,
        ALU_LTS,
        ALU_GTS,
        ALU_EQZ
    } alu_op_t;

endpackage

### sv/wsx_ram.sv
module wsx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### sv/wsx_alu.sv
module wsx_alu (
    input  wsx_pkg::alu_op_t op,
    input  logic [31:0]      a,
    input  logic [31:0]      b,
    output logic [31:0]      res,
    output logic             carry
);
    import wsx_pkg::*;

    logic [32:0] sum;

    assign sum = {1'b0, a} + {1'b0, b};

    always_comb begin
        carry = 1'b0;
        case (op)
            ALU_ADD: begin
                res   = sum[31:0];
                carry = sum[32];
            end
            ALU_SUB: res = a - b;
            ALU_MUL: res = a * b;
            ALU_EQ:  res = {31'b0, a == b};
            ALU_NE:  res = {31'b0, a != b};
            ALU_LTS: res = {31'b0, $signed(a) < $signed(b)};
            ALU_GTS: res = {31'b0, $signed(b) < $signed(a)};
            ALU_EQZ: res = {31'b0, b == 32'd0};
            default: res = 32'd0;
        endcase
    end
endmodule

### sv/wasm_i32_stack_executor_unit.sv
// WebAssembly i32 executor: one pre-decoded instruction per input item.
// Input stream s_*: tdata carries action, immediate, callee_param_count and
// callee_local_count; one result item per input on m_*, carrying status,
// top of the operand stack, stack count and frame depth.
// An item is executed by a sequencer around one ALU and three
// single-port-pair RAMs (operand stack, frame locals, guest bytes).
// Guest memory is read and written one byte per access, and a call copies
// its params and clears its locals one entry at a time (locals cut to the
// frame limit). s_tready is high only while the sequencer is idle, so a
// new item is accepted only once the sequencer has finished the last one.
// After reset the guest memory is cleared one byte a cycle, with s_tready low.
// A finished result sits in an output register; the next item is accepted
// while it waits, and that item is held before its own result until
// m_tready takes the old one.
// A fault latches a sticky status; later items return status 7.
`include "wasm_i32_stack_executor_unit_defines.svh"
module wasm_i32_stack_executor_unit #(
    parameter int STACK_DEPTH      = wsx_pkg::STACK_DEPTH_DEF,
    parameter int MAX_FRAMES       = wsx_pkg::MAX_FRAMES_DEF,
    parameter int LOCALS_PER_FRAME = wsx_pkg::LOCALS_PER_FRAME_DEF,
    parameter int MEM_BYTES        = wsx_pkg::MEM_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // action[4:0], immediate[36:5], callee_param_count[40:37],
    // callee_local_count[47:41]
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[2:0], top_value[34:3], stack_count[45:35], frame_depth[51:46]
    output logic [55:0] m_tdata
);
    import wsx_pkg::*;

    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int DW  = $clog2(MAX_FRAMES + 1);
    localparam int FW  = $clog2(MAX_FRAMES);
    localparam int CW  = $clog2(LOCALS_PER_FRAME + 1);
    localparam int LAW = $clog2(MAX_FRAMES * LOCALS_PER_FRAME);
    localparam int MAW = $clog2(MEM_BYTES);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_DEC, S_RDB, S_RDA, S_EXEC, S_LD, S_LDW, S_ST,
        S_LGW, S_CALL, S_CALLW, S_TOP1, S_TOP2, S_FIN
    } state_t;

    state_t         state_reg, state_next;
    logic [SPW-1:0] sp_reg, sp_next;
    logic [DW-1:0]  depth_reg, depth_next;
    logic [2:0]     halt_reg, halt_next;
    logic [CW-1:0]  lcount_reg [MAX_FRAMES];
    logic [4:0]     act_reg, act_next;
    logic [31:0]    imm_reg, imm_next;
    logic [3:0]     np_reg, np_next;
    logic [CW-1:0]  total_reg, total_next;
    logic [CW-1:0]  ci_reg, ci_next;
    logic [31:0]    a_reg, a_next, b_reg, b_next, acc_reg, acc_next;
    logic [31:0]    top_reg, top_next;
    logic [MAW-1:0] addr_reg, addr_next, clr_reg, clr_next;
    logic [1:0]     bi_reg, bi_next;
    logic [2:0]     st_reg, st_next;
    logic           out_valid_reg, out_valid_next;
    logic [51:0]    out_data_reg, out_data_next;

    logic           lc_we;
    logic [CW-1:0]  lc_wdata;

    logic           stk_we;
    logic [SAW-1:0] stk_waddr, stk_raddr;
    logic [31:0]    stk_wdata, stk_rdata;
    logic           loc_we;
    logic [LAW-1:0] loc_waddr, loc_raddr;
    logic [31:0]    loc_wdata, loc_rdata;
    logic           mem_we;
    logic [MAW-1:0] mem_waddr, mem_raddr;
    logic [7:0]     mem_wdata, mem_rdata;

    alu_op_t        alu_op;
    logic [31:0]    alu_a, alu_b, alu_res;
    logic           alu_carry;
    logic [32:0]    eff_addr;

    logic [CW-1:0]  lc_cur;
    logic [LAW-1:0] cur_loc_addr, new_loc_addr;
    logic           sp_full, lidx_bad;
    logic [8:0]     sum_locals;

    wsx_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
        .aclk(aclk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .raddr(stk_raddr), .rdata(stk_rdata)
    );

    wsx_ram #(.WIDTH(32), .DEPTH(MAX_FRAMES * LOCALS_PER_FRAME)) u_locals (
        .aclk(aclk), .we(loc_we), .waddr(loc_waddr), .wdata(loc_wdata),
        .raddr(loc_raddr), .rdata(loc_rdata)
    );

    wsx_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
        .aclk(aclk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
        .raddr(mem_raddr), .rdata(mem_rdata)
    );

    wsx_alu u_alu (
        .op(alu_op), .a(alu_a), .b(alu_b), .res(alu_res), .carry(alu_carry)
    );

    assign eff_addr = {alu_carry, alu_res};

    // frame index of the active frame is depth-1
    assign lc_cur       = lcount_reg[FW'(depth_reg - 1'b1)];
    assign cur_loc_addr = LAW'(LAW'(depth_reg - 1'b1) * LAW'(LOCALS_PER_FRAME)
                          + LAW'(imm_reg));
    assign new_loc_addr = LAW'(LAW'(depth_reg) * LAW'(LOCALS_PER_FRAME) + LAW'(ci_reg));
    assign sp_full      = (sp_reg == SPW'(STACK_DEPTH));
    assign lidx_bad     = (imm_reg >= 32'(lc_cur));
    assign sum_locals   = 9'(s_tdata[40:37]) + 9'(s_tdata[47:41]);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_data_reg};

    always_comb begin
        case (act_reg)
            ACT_NE:  alu_op = ALU_NE;
            ACT_LTS: alu_op = ALU_LTS;
            ACT_GTS: alu_op = ALU_GTS;
            ACT_EQ:  alu_op = ALU_EQ;
            ACT_SUB: alu_op = ALU_SUB;
            ACT_MUL: alu_op = ALU_MUL;
            ACT_EQZ: alu_op = ALU_EQZ;
            default: alu_op = ALU_ADD;
        endcase
        alu_a = (act_reg == ACT_LD32 || act_reg == ACT_LD8) ? b_reg : a_reg;
        alu_b = (act_reg == ACT_LD32 || act_reg == ACT_LD8 ||
                 act_reg == ACT_ST32 || act_reg == ACT_ST8) ? imm_reg : b_reg;
    end

    always_comb begin
        state_next     = state_reg;
        sp_next        = sp_reg;
        depth_next     = depth_reg;
        halt_next      = halt_reg;
        act_next       = act_reg;
        imm_next       = imm_reg;
        np_next        = np_reg;
        total_next     = total_reg;
        ci_next        = ci_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        acc_next       = acc_reg;
        top_next       = top_reg;
        addr_next      = addr_reg;
        clr_next       = clr_reg;
        bi_next        = bi_reg;
        st_next        = st_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        lc_we          = 1'b0;
        lc_wdata       = total_reg;
        stk_we         = 1'b0;
        stk_waddr      = SAW'(sp_reg);
        stk_wdata      = alu_res;
        stk_raddr      = SAW'(sp_reg - 1'b1);
        loc_we         = 1'b0;
        loc_waddr      = cur_loc_addr;
        loc_wdata      = b_reg;
        loc_raddr      = cur_loc_addr;
        mem_we         = 1'b0;
        mem_waddr      = MAW'(addr_reg + MAW'(bi_reg));
        mem_wdata      = 8'(b_reg >> {bi_reg, 3'b000});
        mem_raddr      = MAW'(addr_reg + MAW'(bi_reg));

        case (state_reg)
            S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = 8'd0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == MAW'(MEM_BYTES - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    act_next   = s_tdata[4:0];
                    imm_next   = s_tdata[36:5];
                    np_next    = s_tdata[40:37];
                    total_next = (sum_locals > 9'(LOCALS_PER_FRAME)) ?
                                 CW'(LOCALS_PER_FRAME) : CW'(sum_locals);
                    state_next = S_DEC;
                end
            end
            S_DEC: begin
                st_next    = ST_OK;
                state_next = S_TOP1;
                if (halt_reg != ST_OK || depth_reg == '0) begin
                    st_next = ST_HALTED;
                end else begin
                    case (act_reg)
                        ACT_END: begin
                            depth_next = depth_reg - 1'b1;
                            if (depth_reg == DW'(1)) st_next = ST_FINISHED;
                        end
                        ACT_BR: begin
                            if (imm_reg == 32'd0) begin
                                depth_next = depth_reg - 1'b1;
                                if (depth_reg == DW'(1)) st_next = ST_FINISHED;
                            end
                        end
                        ACT_DROP, ACT_IF: begin
                            if (sp_reg == '0) st_next = ST_UNDERFLOW;
                            else sp_next = sp_reg - 1'b1;
                        end
                        ACT_CONST: begin
                            if (sp_full) begin
                                st_next = ST_OVERFLOW;
                            end else begin
                                stk_we    = 1'b1;
                                stk_wdata = imm_reg;
                                sp_next   = sp_reg + 1'b1;
                            end
                        end
                        ACT_LGET: begin
                            if (!lidx_bad) begin
                                if (sp_full) st_next = ST_OVERFLOW;
                                else state_next = S_LGW;
                            end
                        end
                        ACT_LSET: begin
                            if (!lidx_bad) begin
                                if (sp_reg == '0) st_next = ST_UNDERFLOW;
                                else state_next = S_RDB;
                            end
                        end
                        ACT_BR_IF, ACT_LD32, ACT_LD8, ACT_EQZ: begin
                            if (sp_reg == '0) st_next = ST_UNDERFLOW;
                            else state_next = S_RDB;
                        end
                        ACT_ST32, ACT_ST8, ACT_NE, ACT_LTS, ACT_GTS, ACT_EQ,
                        ACT_ADD, ACT_SUB, ACT_MUL: begin
                            if (sp_reg < SPW'(2)) st_next = ST_UNDERFLOW;
                            else state_next = S_RDB;
                        end
                        ACT_CALL: begin
                            if (depth_reg >= DW'(MAX_FRAMES)) begin
                                st_next = ST_TOODEEP;
                            end else if (sp_reg < SPW'(np_reg)) begin
                                st_next = ST_UNDERFLOW;
                            end else begin
                                ci_next    = '0;
                                state_next = S_CALL;
                            end
                        end
                        default: st_next = ST_UNREACHABLE;
                    endcase
                end
            end
            S_RDB: begin
                b_next    = stk_rdata;
                stk_raddr = SAW'(sp_reg - SPW'(2));
                if (act_reg == ACT_ST32 || act_reg == ACT_ST8 ||
                    (act_reg >= ACT_NE && act_reg <= ACT_MUL)) begin
                    state_next = S_RDA;
                end else begin
                    state_next = S_EXEC;
                end
            end
            S_RDA: begin
                a_next     = stk_rdata;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                state_next = S_TOP1;
                bi_next    = 2'd0;
                case (act_reg)
                    ACT_BR_IF: begin
                        sp_next = sp_reg - 1'b1;
                        if (b_reg != 32'd0 && imm_reg == 32'd0) begin
                            depth_next = depth_reg - 1'b1;
                            if (depth_reg == DW'(1)) st_next = ST_FINISHED;
                        end
                    end
                    ACT_LSET: begin
                        loc_we  = 1'b1;
                        sp_next = sp_reg - 1'b1;
                    end
                    ACT_LD32, ACT_ST32: begin
                        if (eff_addr > 33'(MEM_BYTES - 4)) begin
                            st_next = ST_MEMFAULT;
                        end else begin
                            addr_next  = MAW'(eff_addr);
                            state_next = (act_reg == ACT_LD32) ? S_LD : S_ST;
                        end
                    end
                    ACT_LD8, ACT_ST8: begin
                        if (eff_addr > 33'(MEM_BYTES - 1)) begin
                            st_next = ST_MEMFAULT;
                        end else begin
                            addr_next  = MAW'(eff_addr);
                            state_next = (act_reg == ACT_LD8) ? S_LD : S_ST;
                        end
                    end
                    ACT_EQZ: begin
                        stk_we    = 1'b1;
                        stk_waddr = SAW'(sp_reg - 1'b1);
                    end
                    default: begin
                        stk_we    = 1'b1;
                        stk_waddr = SAW'(sp_reg - SPW'(2));
                        sp_next   = sp_reg - 1'b1;
                    end
                endcase
            end
            S_LD: begin
                state_next = S_LDW;
            end
            S_LDW: begin
                // gather bytes low first
                acc_next  = {mem_rdata, acc_reg[31:8]};
                stk_waddr = SAW'(sp_reg - 1'b1);
                if (act_reg == ACT_LD8) begin
                    stk_we     = 1'b1;
                    stk_wdata  = {24'd0, mem_rdata};
                    state_next = S_TOP1;
                end else if (bi_reg == 2'd3) begin
                    stk_we     = 1'b1;
                    stk_wdata  = {mem_rdata, acc_reg[31:8]};
                    state_next = S_TOP1;
                end else begin
                    bi_next    = bi_reg + 1'b1;
                    state_next = S_LD;
                end
            end
            S_ST: begin
                mem_we = 1'b1;
                if (act_reg == ACT_ST8 || bi_reg == 2'd3) begin
                    sp_next    = sp_reg - SPW'(2);
                    state_next = S_TOP1;
                end else begin
                    bi_next = bi_reg + 1'b1;
                end
            end
            S_LGW: begin
                stk_we     = 1'b1;
                stk_wdata  = loc_rdata;
                sp_next    = sp_reg + 1'b1;
                state_next = S_TOP1;
            end
            S_CALL: begin
                loc_waddr = new_loc_addr;
                loc_wdata = 32'd0;
                stk_raddr = SAW'(sp_reg - SPW'(np_reg) + SPW'(ci_reg));
                if (ci_reg == total_reg) begin
                    sp_next    = sp_reg - SPW'(np_reg);
                    lc_we      = 1'b1;
                    depth_next = depth_reg + 1'b1;
                    state_next = S_TOP1;
                end else if (9'(ci_reg) < 9'(np_reg)) begin
                    state_next = S_CALLW;
                end else begin
                    loc_we  = 1'b1;
                    ci_next = ci_reg + 1'b1;
                end
            end
            S_CALLW: begin
                loc_we     = 1'b1;
                loc_waddr  = new_loc_addr;
                loc_wdata  = stk_rdata;
                ci_next    = ci_reg + 1'b1;
                state_next = S_CALL;
            end
            S_TOP1: begin
                if (st_reg != ST_OK && st_reg != ST_HALTED) halt_next = st_reg;
                state_next = S_TOP2;
            end
            S_TOP2: begin
                top_next   = (sp_reg != '0) ? stk_rdata : 32'd0;
                state_next = S_FIN;
            end
            S_FIN: begin
                // hold until the output register is free
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = {6'(depth_reg), 11'(sp_reg), top_reg, st_reg};
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLR;
            sp_reg        <= '0;
            depth_reg     <= DW'(1);
            halt_reg      <= ST_OK;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_FRAMES; i++) begin
                lcount_reg[i] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            depth_reg     <= depth_next;
            halt_reg      <= halt_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            if (lc_we) begin
                lcount_reg[FW'(depth_reg)] <= lc_wdata;
            end
        end
        act_reg      <= act_next;
        imm_reg      <= imm_next;
        np_reg       <= np_next;
        total_reg    <= total_next;
        ci_reg       <= ci_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        acc_reg      <= acc_next;
        top_reg      <= top_next;
        addr_reg     <= addr_next;
        bi_reg       <= bi_next;
        st_reg       <= st_next;
        out_data_reg <= out_data_next;
    end

    `WSX_ASSERT_NXT(a_halt_sticky, halt_reg != ST_OK, halt_reg == $past(halt_reg), "halt code changed")
    `WSX_ASSERT_IMP(a_sp_range, 1'b1, sp_reg <= SPW'(STACK_DEPTH), "stack pointer out of range")
    `WSX_ASSERT_IMP(a_depth_range, 1'b1, depth_reg <= DW'(MAX_FRAMES), "frame depth out of range")
    `WSX_ASSERT_IMP(a_no_accept_clear, state_reg == S_CLR, !s_tready, "ready during clear")
    `WSX_ASSERT_NXT(a_halted_frozen, state_reg == S_DEC && halt_reg != ST_OK, sp_reg == $past(sp_reg) && depth_reg == $past(depth_reg), "state moved while halted")
endmodule

### dv/wasm_i32_stack_executor_unit_test.sv
`timescale 1ns / 100ps

module wasm_i32_stack_executor_unit_test;
    import wsx_pkg::*;

    localparam int STK_DEPTH  = 1024;
    localparam int FRAMES     = 32;
    localparam int FRAME_LOCS = 64;
    localparam int MEM_SIZE   = 65536;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int RANDOM_ITEMS = 1500;

    typedef struct packed {
        logic [5:0]  depth;
        logic [10:0] count;
        logic [31:0] top;
        logic [2:0]  status;
    } exec_result_t;

    class exec_scoreboard;
        logic [31:0]  opstk[STK_DEPTH];
        int           sp;
        logic [31:0]  locs[FRAMES * FRAME_LOCS];
        int           lcnt[FRAMES];
        int           depth;
        logic [7:0]   mem[MEM_SIZE];
        logic [2:0]   halt;
        exec_result_t pending_q[$];
        int           errors;

        function new();
            foreach (mem[i]) mem[i] = 8'h00;
            foreach (lcnt[i]) lcnt[i] = 0;
            sp = 0;
            depth = 1;
            halt = ST_OK;
            errors = 0;
        endfunction

        function logic [2:0] close_frame();
            depth--;
            return (depth == 0) ? ST_FINISHED : ST_OK;
        endfunction

        function logic [2:0] run_instruction(logic [4:0] act, logic [31:0] imm,
                                             logic [3:0] np, logic [6:0] nl);
            int f, total, base, len;
            logic [31:0] a, b, r;
            logic [63:0] addr;
            f = depth - 1;
            case (act)
                ACT_END: return close_frame();
                ACT_DROP, ACT_IF: begin
                    if (sp < 1) return ST_UNDERFLOW;
                    sp--;
                    return ST_OK;
                end
                ACT_CALL: begin
                    if (depth >= FRAMES) return ST_TOODEEP;
                    if (sp < np) return ST_UNDERFLOW;
                    total = np + nl;
                    if (total > FRAME_LOCS) total = FRAME_LOCS;
                    base = depth * FRAME_LOCS;
                    for (int i = 0; i < total; i++)
                        locs[base + i] = (i < np) ? opstk[sp - np + i] : 32'h0;
                    sp -= np;
                    lcnt[depth] = total;
                    depth++;
                    return ST_OK;
                end
                ACT_LGET: begin
                    if (imm >= lcnt[f]) return ST_OK;
                    if (sp >= STK_DEPTH) return ST_OVERFLOW;
                    opstk[sp] = locs[f * FRAME_LOCS + imm];
                    sp++;
                    return ST_OK;
                end
                ACT_LSET: begin
                    if (imm >= lcnt[f]) return ST_OK;
                    if (sp < 1) return ST_UNDERFLOW;
                    sp--;
                    locs[f * FRAME_LOCS + imm] = opstk[sp];
                    return ST_OK;
                end
                ACT_CONST: begin
                    if (sp >= STK_DEPTH) return ST_OVERFLOW;
                    opstk[sp] = imm;
                    sp++;
                    return ST_OK;
                end
                ACT_LD32, ACT_LD8: begin
                    if (sp < 1) return ST_UNDERFLOW;
                    len = (act == ACT_LD32) ? 4 : 1;
                    addr = {32'h0, opstk[sp - 1]} + {32'h0, imm};
                    if (addr + len > MEM_SIZE) return ST_MEMFAULT;
                    r = 32'h0;
                    for (int i = 0; i < len; i++) r[8*i +: 8] = mem[addr + i];
                    opstk[sp - 1] = r;
                    return ST_OK;
                end
                ACT_ST32, ACT_ST8: begin
                    if (sp < 2) return ST_UNDERFLOW;
                    len = (act == ACT_ST32) ? 4 : 1;
                    addr = {32'h0, opstk[sp - 2]} + {32'h0, imm};
                    r = opstk[sp - 1];
                    if (addr + len > MEM_SIZE) return ST_MEMFAULT;
                    for (int i = 0; i < len; i++) mem[addr + i] = r[8*i +: 8];
                    sp -= 2;
                    return ST_OK;
                end
                ACT_EQZ: begin
                    if (sp < 1) return ST_UNDERFLOW;
                    opstk[sp - 1] = (opstk[sp - 1] == 32'h0);
                    return ST_OK;
                end
                ACT_NE, ACT_LTS, ACT_GTS, ACT_EQ, ACT_ADD, ACT_SUB, ACT_MUL: begin
                    if (sp < 2) return ST_UNDERFLOW;
                    a = opstk[sp - 2];
                    b = opstk[sp - 1];
                    case (act)
                        ACT_NE:  r = (a != b);
                        ACT_LTS: r = ($signed(a) < $signed(b));
                        ACT_GTS: r = ($signed(b) < $signed(a));
                        ACT_EQ:  r = (a == b);
                        ACT_ADD: r = a + b;
                        ACT_SUB: r = a - b;
                        default: r = a * b;
                    endcase
                    sp--;
                    opstk[sp - 1] = r;
                    return ST_OK;
                end
                ACT_BR: return (imm == 0) ? close_frame() : ST_OK;
                ACT_BR_IF: begin
                    if (sp < 1) return ST_UNDERFLOW;
                    sp--;
                    if (opstk[sp] != 32'h0 && imm == 0) return close_frame();
                    return ST_OK;
                end
                default: return ST_UNREACHABLE;
            endcase
        endfunction

        function void note_instruction(logic [4:0] act, logic [31:0] imm,
                                       logic [3:0] np, logic [6:0] nl);
            exec_result_t res;
            if (halt != ST_OK || depth == 0) begin
                res.status = ST_HALTED;
            end else begin
                res.status = run_instruction(act, imm, np, nl);
                if (res.status != ST_OK) halt = res.status;
            end
            res.top   = (sp > 0) ? opstk[sp - 1] : 32'h0;
            res.count = 11'(sp);
            res.depth = 6'(depth);
            pending_q.push_back(res);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            if (errors < 40)
                $display("%0t mismatch: %s got %h want %h", $realtime, what, got, want);
            errors++;
        endtask

        task check_result(logic [55:0] data);
            exec_result_t got, want;
            got = data[51:0];
            if (pending_q.size() == 0) begin
                report("unexpected item", data[31:0], 32'h0);
            end else begin
                want = pending_q.pop_front();
                if (got.status != want.status) report("status", got.status, want.status);
                if (got.top != want.top) report("top_value", got.top, want.top);
                if (got.count != want.count) report("stack_count", got.count, want.count);
                if (got.depth != want.depth) report("frame_depth", got.depth, want.depth);
            end
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;

    exec_scoreboard sb = new();
    int snd_idle = 23;
    int rcv_idle = 62;
    int cycles = 0;

    wasm_i32_stack_executor_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
        m_tready <= aresetn && ($urandom_range(0, 99) >= rcv_idle);
    end

    task automatic send_item(logic [4:0] act, logic [31:0] imm,
                             logic [3:0] np, logic [6:0] nl);
        while ($urandom_range(0, 99) < snd_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {nl, np, imm, act};
        do @(posedge aclk); while (!s_tready);
        sb.note_instruction(act, imm, np, nl);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 255);
            2: case ($urandom_range(0, 4))
                   0: return 32'h0;
                   1: return 32'h1;
                   2: return 32'h7fffffff;
                   3: return 32'h80000000;
                   default: return 32'hffffffff;
               endcase
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    function automatic logic [31:0] nonzero_word();
        logic [31:0] v;
        v = $urandom;
        return (v == 0) ? 32'h1 : v;
    endfunction

    task automatic push_or_pop();
        if (sb.sp < 48) send_item(ACT_CONST, pick_word(), $urandom, $urandom);
        else send_item(ACT_DROP, $urandom, $urandom, $urandom);
    endtask

    // One well-formed step or short sequence, chosen so the machine keeps running.
    task automatic gen_random_item();
        int r, addr, lim, lc;
        logic [4:0] op;
        logic [31:0] cond;
        r = $urandom_range(0, 99);
        lc = sb.lcnt[sb.depth - 1];
        if (sb.sp > 40 && r < 15) r = 45;
        if (r < 15) begin
            send_item(ACT_CONST, pick_word(), $urandom, $urandom);
        end else if (r < 28) begin
            if (sb.sp >= 2 && $urandom_range(0, 7) != 0)
                send_item(5'(ACT_NE + $urandom_range(0, 6)), $urandom, $urandom, $urandom);
            else if (sb.sp >= 1) send_item(ACT_EQZ, $urandom, $urandom, $urandom);
            else push_or_pop();
        end else if (r < 40) begin
            addr = $urandom_range(0, 1) ? $urandom_range(0, 63) : $urandom_range(0, 65535);
            op = (addr <= 65532 && $urandom_range(0, 1)) ? 5'd4 : 5'd1;
            lim = MEM_SIZE - op - addr;
            if ($urandom_range(0, 1)) lim = (lim > 8) ? 8 : lim;
            send_item(ACT_CONST, addr, $urandom, $urandom);
            if ($urandom_range(0, 1)) begin
                send_item(ACT_CONST, pick_word(), $urandom, $urandom);
                send_item((op == 4) ? ACT_ST32 : ACT_ST8, $urandom_range(0, lim),
                          $urandom, $urandom);
            end else begin
                send_item((op == 4) ? ACT_LD32 : ACT_LD8, $urandom_range(0, lim),
                          $urandom, $urandom);
            end
        end else if (r < 50) begin
            if (sb.sp >= 1)
                send_item($urandom_range(0, 1) ? ACT_DROP : ACT_IF, $urandom, $urandom, $urandom);
            else push_or_pop();
        end else if (r < 58) begin
            if (sb.depth < FRAMES - 1)
                send_item(ACT_CALL, $urandom, $urandom_range(0, (sb.sp < 8) ? sb.sp : 8),
                          $urandom_range(0, 64));
            else push_or_pop();
        end else if (r < 68) begin
            case ($urandom_range(0, 3))
                0: if (sb.depth > 1) send_item(ACT_END, $urandom, $urandom, $urandom);
                   else push_or_pop();
                1: if (sb.depth > 1) send_item(ACT_BR, 32'h0, $urandom, $urandom);
                   else push_or_pop();
                2: send_item(ACT_BR, nonzero_word(), $urandom, $urandom);
                default: begin
                    cond = $urandom_range(0, 1) ? 32'h0 : nonzero_word();
                    send_item(ACT_CONST, cond, $urandom, $urandom);
                    if (sb.depth > 1 || cond == 0)
                        send_item(ACT_BR_IF, $urandom_range(0, 1) ? 32'h0 : nonzero_word(),
                                  $urandom, $urandom);
                    else
                        send_item(ACT_BR_IF, nonzero_word(), $urandom, $urandom);
                end
            endcase
        end else if (r < 88) begin
            op = $urandom_range(0, 1) ? ACT_LGET : ACT_LSET;
            if (lc > 0 && $urandom_range(0, 3) != 0) begin
                if (op == ACT_LSET && sb.sp < 1) push_or_pop();
                else if (op == ACT_LGET && sb.sp > 40) push_or_pop();
                else send_item(op, $urandom_range(0, lc - 1), $urandom, $urandom);
            end else begin
                send_item(op, $urandom_range(0, 1) ? $urandom : $urandom_range(lc, 255),
                          $urandom, $urandom);
            end
        end else begin
            push_or_pop();
        end
    endtask

    // Drive the machine into one randomly chosen halting condition, then poke it.
    task automatic halt_machine();
        case ($urandom_range(0, 6))
            0: send_item(ACT_UNREACHABLE, $urandom, $urandom, $urandom);
            1: send_item(5'($urandom_range(22, 31)), $urandom, $urandom, $urandom);
            2: begin
                send_item(ACT_CONST, 32'hffff_fffd - $urandom_range(0, 2), $urandom, $urandom);
                send_item(ACT_LD32, $urandom_range(0, 1), $urandom, $urandom);
            end
            3: begin
                while (sb.depth < FRAMES) send_item(ACT_CALL, $urandom, 4'd0, 7'd0);
                send_item(ACT_CALL, $urandom, 4'd0, 7'd0);
            end
            4: begin
                while (sb.sp > 0) send_item(ACT_DROP, $urandom, $urandom, $urandom);
                send_item(ACT_DROP, $urandom, $urandom, $urandom);
            end
            5: begin
                while (sb.sp < STK_DEPTH) send_item(ACT_CONST, $urandom, $urandom, $urandom);
                send_item(ACT_CONST, $urandom, $urandom, $urandom);
            end
            default: while (sb.depth > 0) send_item(ACT_END, $urandom, $urandom, $urandom);
        endcase
        repeat (5) send_item(5'($urandom), $urandom, $urandom, $urandom);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        send_item(ACT_CONST, 32'h7fffffff, 4'd15, 7'd127);
        send_item(ACT_CONST, 32'h80000000, 4'd0, 7'd0);
        send_item(ACT_LTS, 32'h0, 4'd0, 7'd0);
        send_item(ACT_CONST, 32'hffffffff, 4'd0, 7'd0);
        send_item(ACT_GTS, 32'h0, 4'd0, 7'd0);
        send_item(ACT_CONST, 32'h0, 4'd0, 7'd0);
        send_item(ACT_EQ, 32'h0, 4'd0, 7'd0);
        send_item(ACT_EQZ, 32'h0, 4'd0, 7'd0);
        send_item(ACT_CONST, 32'd5, 4'd0, 7'd0);
        send_item(ACT_NE, 32'h0, 4'd0, 7'd0);
        send_item(ACT_CONST, -32'sd3, 4'd0, 7'd0);
        send_item(ACT_ADD, 32'h0, 4'd0, 7'd0);
        send_item(ACT_CONST, 32'd7, 4'd0, 7'd0);
        send_item(ACT_SUB, 32'h0, 4'd0, 7'd0);
        send_item(ACT_CONST, 32'hffffffff, 4'd0, 7'd0);
        send_item(ACT_MUL, 32'h0, 4'd0, 7'd0);
        // word access right at the top of guest memory
        send_item(ACT_CONST, 32'd65532, 4'd0, 7'd0);
        send_item(ACT_CONST, 32'hdeadbeef, 4'd0, 7'd0);
        send_item(ACT_ST32, 32'h0, 4'd0, 7'd0);
        send_item(ACT_CONST, 32'd65500, 4'd0, 7'd0);
        send_item(ACT_LD32, 32'd32, 4'd0, 7'd0);
        send_item(ACT_CONST, 32'h0, 4'd0, 7'd0);
        send_item(ACT_CONST, 32'h1ab, 4'd0, 7'd0);
        send_item(ACT_ST8, 32'd65535, 4'd0, 7'd0);
        send_item(ACT_CONST, 32'h0, 4'd0, 7'd0);
        send_item(ACT_LD8, 32'd65535, 4'd0, 7'd0);
        // oversized frame: params plus locals cut to the frame limit
        send_item(ACT_CALL, 32'h0, 4'd3, 7'd64);
        send_item(ACT_LGET, 32'd0, 4'd0, 7'd0);
        send_item(ACT_LSET, 32'd63, 4'd0, 7'd0);
        send_item(ACT_LGET, 32'd64, 4'd0, 7'd0);
        send_item(ACT_LGET, 32'd63, 4'd0, 7'd0);
        send_item(ACT_IF, 32'h0, 4'd0, 7'd0);
        send_item(ACT_BR, 32'd5, 4'd0, 7'd0);
        send_item(ACT_CONST, 32'd1, 4'd0, 7'd0);
        send_item(ACT_BR_IF, 32'h0, 4'd0, 7'd0);
        send_item(ACT_CALL, 32'h0, 4'd0, 7'd0);
        send_item(ACT_END, 32'h0, 4'd0, 7'd0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3) begin
                snd_idle = 62;
                rcv_idle = 23;
            end else if (n == 2 * RANDOM_ITEMS / 3) begin
                snd_idle = 0;
                rcv_idle = 0;
            end
            gen_random_item();
        end
        halt_machine();
        s_tvalid <= 1'b0;

        while (sb.pending_q.size() > 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (sb.errors == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end
endmodule
